[hdl/bsub_pkg.sv]
`timescale 1ns / 1ps
package bsub_pkg;

    localparam int PARAM_FRAC_BITS = 16;
    localparam int T_W             = PARAM_FRAC_BITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << PARAM_FRAC_BITS;
    localparam int COORD_W         = 32;
    localparam int PTS_W           = 8 * COORD_W;
    localparam int IN_DATA_W       = ((PTS_W + 2 * T_W + 7) / 8) * 8;
    localparam int OUT_DATA_W      = PTS_W;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);

    localparam logic [1:0] ACT_SPLIT_ONE = 2'd0;
    localparam logic [1:0] ACT_SPLIT_TWO = 2'd1;
    localparam logic [1:0] ACT_EXTRACT   = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pt_t;

    typedef pt_t [3:0] curve_t;

    typedef struct packed {
        logic [1:0]     action;
        logic           cubic;
        logic [T_W-1:0] t1;
        logic [T_W-1:0] t2;
        curve_t         p;
    } item_t;

    // index 0 belongs to t1, index 1 to t2
    typedef struct packed {
        item_t      item;
        pt_t [1:0]  q;
        pt_t [1:0]  r;
        pt_t [1:0]  s;
        pt_t [1:0]  qr;
        pt_t [1:0]  rs;
        pt_t        qa;
        pt_t        qb;
        pt_t [1:0]  m;
        pt_t        c1;
        pt_t        c2;
    } bundle_t;

    function automatic logic [T_W-1:0] sat_param(input logic [T_W-1:0] raw);
        return (raw > T_ONE) ? T_ONE : raw;
    endfunction

    // a + floor((b - a) * t / one); result always lies between a and b
    function automatic logic signed [COORD_W-1:0] lerp1(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [T_W-1:0]            t
    );
        logic signed [COORD_W:0]       d;
        logic signed [COORD_W+T_W+1:0] prod;
        d    = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        prod = d * $signed({1'b0, t});
        return a + prod[PARAM_FRAC_BITS +: COORD_W];
    endfunction

    function automatic pt_t lerp_pt(input pt_t a, input pt_t b, input logic [T_W-1:0] t);
        pt_t r;
        r.x = lerp1(a.x, b.x, t);
        r.y = lerp1(a.y, b.y, t);
        return r;
    endfunction

endpackage

[hdl/bsub_front.sv]
`timescale 1ns / 1ps
module bsub_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bsub_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [2:0]                         s_tuser,
    input  logic                               q_full,
    output logic                               q_push,
    output bsub_pkg::item_t                    q_item
);

    logic accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        q_item.action = s_tuser[1:0];
        q_item.cubic  = s_tuser[2];
        q_item.t1 = bsub_pkg::sat_param(s_tdata[bsub_pkg::PTS_W +: bsub_pkg::T_W]);
        q_item.t2 = bsub_pkg::sat_param(
            s_tdata[bsub_pkg::PTS_W + bsub_pkg::T_W +: bsub_pkg::T_W]);
        for (int i = 0; i < 4; i++)
        begin
            q_item.p[i].x = s_tdata[2*bsub_pkg::COORD_W*i +: bsub_pkg::COORD_W];
            q_item.p[i].y = s_tdata[2*bsub_pkg::COORD_W*i + bsub_pkg::COORD_W +:
                                    bsub_pkg::COORD_W];
        end
    end

    // drop items with no results right here
    assign q_push = accept && (s_tuser[1:0] != bsub_pkg::ACT_NONE);

    property p_push_needs_room;
        @(posedge clk) disable iff (!rst_n) q_push |-> !q_full;
    endproperty
    a_push_needs_room: assert property (p_push_needs_room) else $error("push into full queue");

    property p_none_dropped;
        @(posedge clk) disable iff (!rst_n)
            (accept && s_tuser[1:0] == bsub_pkg::ACT_NONE) |-> !q_push;
    endproperty
    a_none_dropped: assert property (p_none_dropped) else $error("empty action queued");

    property p_push_is_accept;
        @(posedge clk) disable iff (!rst_n) q_push |-> (s_tvalid && s_tready);
    endproperty
    a_push_is_accept: assert property (p_push_is_accept) else $error("push without accept");

endmodule

[hdl/bsub_queue.sv]
`timescale 1ns / 1ps
module bsub_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bsub_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output bsub_pkg::item_t  head
);

    bsub_pkg::item_t mem [bsub_pkg::QDEPTH];
    logic [bsub_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bsub_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bsub_pkg::QPTR_W:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (bsub_pkg::QPTR_W+1)'(bsub_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (bsub_pkg::QPTR_W+1)'(push) - (bsub_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) pop |-> not_empty;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) (push && full) |-> pop;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
            cnt_reg <= (bsub_pkg::QPTR_W+1)'(bsub_pkg::QDEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

endmodule

[hdl/bsub_back.sv]
`timescale 1ns / 1ps
module bsub_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  bsub_pkg::item_t                    q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bsub_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    bsub_pkg::bundle_t s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;
    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic adv, load;

    bsub_pkg::curve_t em_pc_reg [3];
    bsub_pkg::curve_t em_pc_next [3];
    logic [1:0] em_cnt_reg, em_cnt_next;
    logic [1:0] em_idx_reg;
    logic       em_v_reg;
    logic       em_last;
    logic       em_take;

    assign em_last = (em_idx_reg == em_cnt_reg - 2'd1);
    assign em_take = em_v_reg && m_tready;
    assign load    = s3_v_reg && (!em_v_reg || (em_take && em_last));
    assign adv     = !s3_v_reg || load;
    assign q_pop   = adv && q_not_empty;

    // level one: first lerps at both parameters
    always_comb
    begin
        s1_next      = '0;
        s1_next.item = q_head;
        for (int j = 0; j < 2; j++)
        begin
            logic [bsub_pkg::T_W-1:0] t;
            t = (j == 0) ? q_head.t1 : q_head.t2;
            s1_next.q[j] = bsub_pkg::lerp_pt(q_head.p[0], q_head.p[1], t);
            s1_next.r[j] = bsub_pkg::lerp_pt(q_head.p[1], q_head.p[2], t);
            s1_next.s[j] = bsub_pkg::lerp_pt(q_head.p[2], q_head.p[3], t);
        end
    end

    // level two, plus the quadratic cross terms
    always_comb
    begin
        s2_next = s1_reg;
        for (int j = 0; j < 2; j++)
        begin
            logic [bsub_pkg::T_W-1:0] t;
            t = (j == 0) ? s1_reg.item.t1 : s1_reg.item.t2;
            s2_next.qr[j] = bsub_pkg::lerp_pt(s1_reg.q[j], s1_reg.r[j], t);
            s2_next.rs[j] = bsub_pkg::lerp_pt(s1_reg.r[j], s1_reg.s[j], t);
        end
        s2_next.qa = bsub_pkg::lerp_pt(s1_reg.q[0], s1_reg.r[0], s1_reg.item.t2);
        s2_next.qb = bsub_pkg::lerp_pt(s1_reg.q[1], s1_reg.r[1], s1_reg.item.t1);
    end

    // level three: cubic midpoints and cross terms
    always_comb
    begin
        s3_next      = s2_reg;
        s3_next.m[0] = bsub_pkg::lerp_pt(s2_reg.qr[0], s2_reg.rs[0], s2_reg.item.t1);
        s3_next.m[1] = bsub_pkg::lerp_pt(s2_reg.qr[1], s2_reg.rs[1], s2_reg.item.t2);
        s3_next.c1   = bsub_pkg::lerp_pt(s2_reg.qr[0], s2_reg.rs[0], s2_reg.item.t2);
        s3_next.c2   = bsub_pkg::lerp_pt(s2_reg.qr[1], s2_reg.rs[1], s2_reg.item.t1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= q_not_empty;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // assemble all pieces of the item in s3
    always_comb
    begin
        bsub_pkg::pt_t   z;
        bsub_pkg::item_t it;
        z  = '0;
        it = s3_reg.item;
        for (int k = 0; k < 3; k++)
        begin
            em_pc_next[k] = '0;
        end
        em_cnt_next = 2'd1;
        if (it.cubic)
        begin
            case (it.action)
                bsub_pkg::ACT_SPLIT_ONE:
                begin
                    em_pc_next[0] = {s3_reg.m[0], s3_reg.qr[0], s3_reg.q[0], it.p[0]};
                    em_pc_next[1] = {it.p[3], s3_reg.s[0], s3_reg.rs[0], s3_reg.m[0]};
                    em_cnt_next   = 2'd2;
                end
                bsub_pkg::ACT_SPLIT_TWO:
                begin
                    em_pc_next[0] = {s3_reg.m[0], s3_reg.qr[0], s3_reg.q[0], it.p[0]};
                    em_pc_next[1] = {s3_reg.m[1], s3_reg.c2, s3_reg.c1, s3_reg.m[0]};
                    em_pc_next[2] = {it.p[3], s3_reg.s[1], s3_reg.rs[1], s3_reg.m[1]};
                    em_cnt_next   = 2'd3;
                end
                default:
                begin
                    em_pc_next[0] = {s3_reg.m[1], s3_reg.c2, s3_reg.c1, s3_reg.m[0]};
                end
            endcase
        end
        else
        begin
            case (it.action)
                bsub_pkg::ACT_SPLIT_ONE:
                begin
                    em_pc_next[0] = {z, s3_reg.qr[0], s3_reg.q[0], it.p[0]};
                    em_pc_next[1] = {z, it.p[2], s3_reg.r[0], s3_reg.qr[0]};
                    em_cnt_next   = 2'd2;
                end
                bsub_pkg::ACT_SPLIT_TWO:
                begin
                    em_pc_next[0] = {z, s3_reg.qr[0], s3_reg.q[0], it.p[0]};
                    em_pc_next[1] = {z, s3_reg.qr[1], s3_reg.qa, s3_reg.qr[0]};
                    em_pc_next[2] = {z, it.p[2], s3_reg.r[1], s3_reg.qr[1]};
                    em_cnt_next   = 2'd3;
                end
                default:
                begin
                    em_pc_next[0] = {z, s3_reg.qr[1], s3_reg.qb, s3_reg.qr[0]};
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            em_pc_reg  <= em_pc_next;
            em_cnt_reg <= em_cnt_next;
        end
        else if (em_take)
        begin
            // advance to the next piece
            em_pc_reg[0] <= em_pc_reg[1];
            em_pc_reg[1] <= em_pc_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_v_reg   <= 1'b0;
            em_idx_reg <= 2'd0;
        end
        else if (load)
        begin
            em_v_reg   <= 1'b1;
            em_idx_reg <= 2'd0;
        end
        else if (em_take)
        begin
            em_v_reg   <= !em_last;
            em_idx_reg <= em_idx_reg + 2'd1;
        end
    end

    assign m_tvalid = em_v_reg;
    assign m_tuser  = em_idx_reg;
    assign m_tlast  = em_last;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            m_tdata[2*bsub_pkg::COORD_W*i +: bsub_pkg::COORD_W] = em_pc_reg[0][i].x;
            m_tdata[2*bsub_pkg::COORD_W*i + bsub_pkg::COORD_W +: bsub_pkg::COORD_W] =
                em_pc_reg[0][i].y;
        end
    end

    property p_load_only_when_free;
        @(posedge clk) disable iff (!rst_n)
            load |-> (!em_v_reg || (m_tready && em_last));
    endproperty
    a_load_only_when_free: assert property (p_load_only_when_free)
        else $error("emitter overwritten");

    property p_idx_in_range;
        @(posedge clk) disable iff (!rst_n) em_v_reg |-> (em_idx_reg < em_cnt_reg);
    endproperty
    a_idx_in_range: assert property (p_idx_in_range) else $error("piece index past count");

    property p_s3_held;
        @(posedge clk) disable iff (!rst_n) (s3_v_reg && !adv) |=> s3_v_reg;
    endproperty
    a_s3_held: assert property (p_s3_held) else $error("stalled item lost");

    property p_idle_after_last;
        @(posedge clk) disable iff (!rst_n)
            (em_take && em_last && !load) |=> !m_tvalid;
    endproperty
    a_idle_after_last: assert property (p_idle_after_last) else $error("extra piece");

endmodule

[hdl/bezier_subdivider_core.sv]
`timescale 1ns / 1ps
// Subdivides one quadratic or cubic Bezier curve per input item by de Casteljau.
// Input channel s_*: tuser = {is_cubic, action}; tdata holds p0_x, p0_y .. p3_y
// (32 bits each, signed Q16.16) then t_first and t_second (17 bits, unsigned Q1.16).
// Action 0 gives two pieces, action 1 three, action 2 one; action 3 is taken
// and gives nothing. Parameters above 1.0 are clamped to 1.0.
// Output channel m_*: tdata holds q0_x .. q3_y, tuser the piece index, tlast
// marks the final piece of an input item. Quadratic pieces carry q3 = 0.
// Path: the queue is written at the accepting edge, then the item passes three
// registered interpolation levels and the piece register.
// Throughput: one item per cycle through the interpolation levels unless they
// stall behind the output; the output register sends one piece per cycle
// while m_tready is high, and an item has 1 to 3 pieces at the output port.
// A four-entry queue separates intake from the datapath: s_tready drops only
// when it is full. When m_tready is low, the current piece holds and the
// datapath stalls behind it. Reset empties the queue and all valid flags.
module bezier_subdivider_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_first, t_second, zero pad
    input  logic [bsub_pkg::IN_DATA_W-1:0]     s_tdata,
    // action, is_cubic
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y
    output logic [bsub_pkg::OUT_DATA_W-1:0]    m_tdata,
    // piece
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    logic            q_full, q_push, q_pop, q_not_empty;
    bsub_pkg::item_t q_item, q_head;

    bsub_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    bsub_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bsub_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
